// ----- rtl/nca_pkg.sv -----
// ----------------------------------------------------------------------------
// nca_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the nearest centroid assignment core.
// ----------------------------------------------------------------------------
package nca_pkg;

  localparam int MAX_CENTERS = 64;
  localparam int MAX_DIMS    = 256;

  localparam int CIDX_W     = $clog2(MAX_CENTERS);
  localparam int DIDX_W     = $clog2(MAX_DIMS);
  localparam int COORD_W    = 16;
  localparam int NC_W       = 7;
  localparam int ND_W       = 9;
  localparam int DIST_W     = 40;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W + 1;
  localparam int CADDR_W    = CIDX_W + DIDX_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 1'b1;

  localparam logic [NC_W-1:0] NUM_CENTERS_RST = 7'd16;
  localparam logic [ND_W-1:0] NUM_DIMS_RST    = 9'd16;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic issue;
    logic load_out;
  } nca_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic complete;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } nca_stat_t;

endpackage

// ----- rtl/nca_ctrl.sv -----
// ----------------------------------------------------------------------------
// nca_ctrl
// Sequencer: accepts words, launches the distance sweep on point
// completion, waits for the pipeline to drain and hands off the result.
// ----------------------------------------------------------------------------
module nca_ctrl
  import nca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  nca_stat_t stat,
  output nca_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.accept   = accept;
    cmd.start    = accept && stat.complete;
    cmd.issue    = (state == ST_RUN);
    cmd.load_out = (state == ST_DONE) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && stat.complete) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (stat.last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/nca_dp.sv -----
// ----------------------------------------------------------------------------
// nca_dp
// Datapath: config registers, center and point memories, address sweep,
// square/accumulate pipeline, running minimum and output register.
// ----------------------------------------------------------------------------
module nca_dp
  import nca_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  nca_cmd_t                      cmd,
  output nca_stat_t                     stat,
  input  logic                          mode,
  input  logic [CIDX_W-1:0]             center_index,
  input  logic [DIDX_W-1:0]             dim_index,
  input  logic signed [COORD_W-1:0]     coord_value,
  input  logic                          cfg_valid,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [NC_W-1:0]               cluster_number,
  output logic [DIST_W-1:0]             best_distance
);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  logic [NC_W-1:0]   num_centers;
  logic [ND_W-1:0]   num_dims;
  logic [ND_W-1:0]   nd_m1;
  logic [NC_W-1:0]   nc_m1;
  logic [DIDX_W-1:0] dims_last;
  logic [CIDX_W-1:0] cent_last;

  logic [COORD_W-1:0] center_mem [MAX_CENTERS*MAX_DIMS];
  logic [COORD_W-1:0] point_mem  [MAX_DIMS];

  logic [CIDX_W-1:0] c_cnt;
  logic [DIDX_W-1:0] i_cnt;
  logic              i_wrap;

  logic              v1, v2, v3;
  logic              first1, first2;
  logic              last1, last2, last3;
  logic [CIDX_W-1:0] c1, c2, c3;
  logic signed [COORD_W-1:0] pt_q, ce_q;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]   sq;
  logic [DIST_W-1:0] acc;
  logic [DIST_W:0]   acc_sum;
  logic [DIST_W-1:0] acc_next;

  logic [CIDX_W-1:0] best_c;
  logic [DIST_W-1:0] best_d;

  // config registers; out-of-range values saturate at use
  always_ff @(posedge clk) begin
    if (rst) begin
      num_centers <= NUM_CENTERS_RST;
      num_dims    <= NUM_DIMS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_CENTERS: num_centers <= cfg_data[NC_W-1:0];
        REG_NUM_DIMS:    num_dims    <= cfg_data[ND_W-1:0];
        default: ;
      endcase
    end
  end

  assign nd_m1 = num_dims - ND_W'(1);
  assign nc_m1 = num_centers - NC_W'(1);

  always_comb begin
    if (num_dims == '0) begin
      dims_last = '0;
    end else if (num_dims > ND_W'(MAX_DIMS)) begin
      dims_last = DIDX_W'(MAX_DIMS - 1);
    end else begin
      dims_last = nd_m1[DIDX_W-1:0];
    end
    if (num_centers == '0) begin
      cent_last = '0;
    end else if (num_centers > NC_W'(MAX_CENTERS)) begin
      cent_last = CIDX_W'(MAX_CENTERS - 1);
    end else begin
      cent_last = nc_m1[CIDX_W-1:0];
    end
  end

  assign i_wrap = (i_cnt == dims_last);

  always_comb begin
    stat.complete   = (mode == MODE_POINT) && (dim_index == dims_last);
    stat.last_issue = i_wrap && (c_cnt == cent_last);
    stat.pipe_busy  = v1 || v2 || v3;
    stat.out_free   = !out_valid || out_ready;
  end

  // center store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && mode == MODE_LOAD) begin
      center_mem[{center_index, dim_index}] <= coord_value;
    end
    ce_q <= center_mem[{c_cnt, i_cnt}];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && mode == MODE_POINT) begin
      point_mem[dim_index] <= coord_value;
    end
    pt_q <= point_mem[i_cnt];
  end

  // address sweep: dims inner, centers outer
  always_ff @(posedge clk) begin
    if (rst) begin
      c_cnt <= '0;
      i_cnt <= '0;
    end else if (cmd.start) begin
      c_cnt <= '0;
      i_cnt <= '0;
    end else if (cmd.issue) begin
      if (i_wrap) begin
        i_cnt <= '0;
        c_cnt <= c_cnt + CIDX_W'(1);
      end else begin
        i_cnt <= i_cnt + DIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign diff = {pt_q[COORD_W-1], pt_q} - {ce_q[COORD_W-1], ce_q};
  assign prod = diff * diff;

  assign acc_sum  = {1'b0, acc} + (DIST_W+1)'(sq);
  assign acc_next = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    first1 <= (i_cnt == '0);
    last1  <= i_wrap;
    c1     <= c_cnt;
    first2 <= first1;
    last2  <= last1;
    c2     <= c1;
    sq     <= prod[SQ_W-1:0];
    last3  <= last2;
    c3     <= c2;
    if (v2) begin
      acc <= first2 ? DIST_W'(sq) : acc_next;
    end
  end

  // running minimum, ties keep the lower center
  always_ff @(posedge clk) begin
    if (v3 && last3 && (c3 == '0 || acc < best_d)) begin
      best_d <= acc;
      best_c <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cluster_number <= NC_W'(best_c) + NC_W'(1);
      best_distance  <= best_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_pipe_from_issue: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $past(cmd.issue))
    else $error("read pipeline advanced without an address");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (c_cnt <= cent_last))
    else $error("center sweep past last center");

  a_sweep_stops: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && stat.last_issue) |=> !cmd.issue)
    else $error("address issued after last center");
`endif

endmodule

// ----- rtl/nearest_centroid_assign_core.sv -----
// ----------------------------------------------------------------------------
// nearest_centroid_assign_core
// Nearest cluster center by squared euclidean distance over stored centers.
//
//   channel | handshake            | word
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_ready  | mode, center_index, dim_index, coord_value
//   out     | out_valid / out_ready| cluster_number, best_distance
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// loads and non-final point words are stored on acceptance; the core stays ready for the next word.
// a final point word sweeps num_centers * num_dims memory reads, one per
// cycle, then drains the pipeline and hands off the result.
// the finished result waits in an output register; loads continue meanwhile.
// synchronous reset restores the control and config registers; the memories are not cleared.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_core
  import nca_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [CIDX_W-1:0]         center_index,
  input  logic [DIDX_W-1:0]         dim_index,
  input  logic signed [COORD_W-1:0] coord_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [NC_W-1:0]           cluster_number,
  output logic [DIST_W-1:0]         best_distance,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  nca_cmd_t  cmd;
  nca_stat_t stat;

  assign cfg_ready = 1'b1;

  nca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nca_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (mode),
    .center_index   (center_index),
    .dim_index      (dim_index),
    .coord_value    (coord_value),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cluster_number (cluster_number),
    .best_distance  (best_distance)
  );

endmodule
